// ----- design/b64d_pkg.sv -----
`default_nettype none
package b64d_pkg;

  localparam int CODE_W     = 21;
  localparam int SEXTET_W   = 6;
  localparam int GROUP_W    = 18;
  localparam int JOB_QDEPTH = 4;
  localparam int JOB_QPTR_W = $clog2(JOB_QDEPTH);

  localparam logic [CODE_W-1:0] CHAR_NUL   = CODE_W'(0);
  localparam logic [CODE_W-1:0] CHAR_UP_A  = CODE_W'(65);
  localparam logic [CODE_W-1:0] CHAR_UP_Z  = CODE_W'(90);
  localparam logic [CODE_W-1:0] CHAR_LO_A  = CODE_W'(97);
  localparam logic [CODE_W-1:0] CHAR_LO_Z  = CODE_W'(122);
  localparam logic [CODE_W-1:0] CHAR_DIG_0 = CODE_W'(48);
  localparam logic [CODE_W-1:0] CHAR_DIG_9 = CODE_W'(57);
  localparam logic [CODE_W-1:0] CHAR_PLUS  = CODE_W'(43);
  localparam logic [CODE_W-1:0] CHAR_SLASH = CODE_W'(47);
  localparam logic [CODE_W-1:0] CHAR_PAD   = CODE_W'(61);

  localparam logic [SEXTET_W-1:0] SEXTET_LO_BASE  = SEXTET_W'(26);
  localparam logic [SEXTET_W-1:0] SEXTET_DIG_BASE = SEXTET_W'(52);
  localparam logic [SEXTET_W-1:0] SEXTET_PLUS     = SEXTET_W'(62);
  localparam logic [SEXTET_W-1:0] SEXTET_SLASH    = SEXTET_W'(63);

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SKIPPED   = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // results caused by one item: num_bytes bytes, oldest in byte0, then status
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] num_bytes;
    logic       has_status;
    logic [1:0] status;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic                valid;
    logic [SEXTET_W-1:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [CODE_W-1:0] c);
    sextet_t r;
    logic [CODE_W-1:0] d;
    r.valid = 1'b1;
    r.value = '0;
    d       = '0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      d       = c - CHAR_UP_A;
      r.value = d[SEXTET_W-1:0];
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      d       = c - CHAR_LO_A;
      r.value = d[SEXTET_W-1:0] + SEXTET_LO_BASE;
    end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
      d       = c - CHAR_DIG_0;
      r.value = d[SEXTET_W-1:0] + SEXTET_DIG_BASE;
    end else if (c == CHAR_PLUS) begin
      r.value = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      r.value = SEXTET_SLASH;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/b64d_front.sv -----
`default_nettype none
module b64d_front import b64d_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_item_t item,
  output logic          push,
  output job_t          job
);

  logic [GROUP_W-1:0] group_r, group_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               skipped_r, skipped_nxt;
  logic               padded_r, padded_nxt;
  sextet_t            sx;
  logic               closing;
  logic [GROUP_W+SEXTET_W-1:0] full_group;

  always_comb begin
    sx          = sextet_of(item.code);
    closing     = item.end_of_input || (item.code == CHAR_NUL);
    group_nxt   = group_r;
    count_nxt   = count_r;
    skipped_nxt = skipped_r;
    padded_nxt  = padded_r;
    full_group  = {group_r, sx.value};
    job         = '0;

    if (item.code != CHAR_NUL) begin
      if (item.code == CHAR_PAD) begin
        padded_nxt = 1'b1;
      end else if (!sx.valid) begin
        skipped_nxt = 1'b1;
      end else if (!padded_r) begin
        if (count_r == 2'd3) begin
          job.byte0     = full_group[23:16];
          job.byte1     = full_group[15:8];
          job.byte2     = full_group[7:0];
          job.num_bytes = 2'd3;
          group_nxt     = '0;
          count_nxt     = 2'd0;
        end else begin
          group_nxt = {group_r[GROUP_W-SEXTET_W-1:0], sx.value};
          count_nxt = count_r + 2'd1;
        end
      end
    end

    if (closing) begin
      job.has_status = 1'b1;
      job.status     = skipped_nxt ? STATUS_SKIPPED : STATUS_OK;
      unique case (count_nxt)
        2'd0: ;
        2'd1: job.status = STATUS_MALFORMED;
        2'd2: begin
          job.byte0     = group_nxt[11:4];
          job.num_bytes = 2'd1;
        end
        2'd3: begin
          job.byte0     = group_nxt[17:10];
          job.byte1     = group_nxt[9:2];
          job.num_bytes = 2'd2;
        end
        default: ;
      endcase
      group_nxt   = '0;
      count_nxt   = 2'd0;
      skipped_nxt = 1'b0;
      padded_nxt  = 1'b0;
    end

    push = accept && (job.has_status || (job.num_bytes != 2'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r   <= '0;
      count_r   <= 2'd0;
      skipped_r <= 1'b0;
      padded_r  <= 1'b0;
    end else if (accept) begin
      group_r   <= group_nxt;
      count_r   <= count_nxt;
      skipped_r <= skipped_nxt;
      padded_r  <= padded_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/b64d_queue.sv -----
`default_nettype none
module b64d_queue import b64d_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output q_stat_t   stat
);

  job_t                  mem [JOB_QDEPTH];
  logic [JOB_QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOB_QPTR_W:0]   count_r, count_nxt;
  logic                  do_push, do_pop;

  always_comb begin
    stat.full  = (count_r == (JOB_QPTR_W+1)'(JOB_QDEPTH));
    stat.empty = (count_r == '0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    count_nxt  = count_r + (JOB_QPTR_W+1)'(do_push) - (JOB_QPTR_W+1)'(do_pop);
    head       = mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/b64d_back.sv -----
`default_nettype none
module b64d_back import b64d_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire job_t    head,
  input  wire q_stat_t stat,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_item_t    out_item
);

  logic       out_valid_r;
  out_item_t  out_item_r, res;
  logic [1:0] idx_r;
  logic       load, take;

  always_comb begin
    load = !out_valid_r || out_ready;
    take = load && !stat.empty;
    res  = '0;
    if (idx_r < head.num_bytes) begin
      unique case (idx_r)
        2'd0:    res.data = head.byte0;
        2'd1:    res.data = head.byte1;
        default: res.data = head.byte2;
      endcase
      res.last = (idx_r == head.num_bytes - 2'd1) && !head.has_status;
    end else begin
      res.is_status = 1'b1;
      res.status    = head.status;
      res.last      = 1'b1;
    end
    pop = take && res.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= take;
      if (take) begin
        idx_r <= res.last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ----- design/base64_stream_decoder.sv -----
// Base64 stream decoder: one character item in, data bytes and a closing status item out.
// Path: the results of an accepted item are written into the job queue, and the first of them
//   is then loaded from the queue head into the output register.
// Throughput: one input item per cycle while the 4-entry job queue has room; results
//   leave at one per cycle from the output register while out_ready is high.
// Reset: synchronous active-low rst_n clears decode state, queue and output valid.
`default_nettype none
module base64_stream_decoder import b64d_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic    push, pop, accept;
  job_t    job, head;
  q_stat_t stat;

  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;

  b64d_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .push   (push),
    .job    (job)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
